### rtl/cea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cea_pkg;

    localparam int DISK_BLOCKS_DEF = 32;
    localparam int DIR_SLOTS_DEF   = 16;
    localparam int NAME_CHARS_DEF  = 9;

    localparam int NAME_LEN  = 9;
    localparam int NAME_W    = 8 * NAME_LEN;
    localparam int HEAD_W    = 64;
    localparam int TAIL_W    = 8;
    localparam int START_W   = 5;
    localparam int COUNT_W   = 6;
    localparam int STATUS_W  = 3;
    localparam int SLOT_W    = 4;
    localparam int MAP_W     = 32;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED   = 3'd0,
        ST_NOSPACE  = 3'd1,
        ST_DIRFULL  = 3'd2,
        ST_DELETED  = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef struct packed {
        logic [NAME_W-1:0]  name;
        logic [START_W-1:0] start;
        logic [COUNT_W-1:0] length;
    } t_entry;

    typedef struct packed {
        logic               set_used;
        logic               set_free;
        logic [START_W-1:0] start;
        logic [COUNT_W-1:0] count;
    } t_map_ctl;

    // A name ends at its first zero character and keeps at most nchars characters.
    function automatic logic [NAME_W-1:0] norm_name(
        input logic [HEAD_W-1:0] head,
        input logic [TAIL_W-1:0] tail,
        input int unsigned       nchars
    );
        logic [NAME_W-1:0] raw;
        logic [NAME_W-1:0] res;
        logic              ended;
        raw   = {tail, head};
        res   = '0;
        ended = 1'b0;
        for (int k = 0; k < NAME_LEN; k++) begin
            if (raw[8*k +: 8] == 8'd0) begin
                ended = 1'b1;
            end
            if (!ended && (k < int'(nchars))) begin
                res[8*k +: 8] = raw[8*k +: 8];
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/contiguous_extent_allocator.sv
// Flow: a create passes through S_CREATE and then S_PUSH before its result is registered; a
// delete passes through S_SEARCH, where the name search reads one directory entry per cycle.
// A new transaction is accepted once its predecessor's result is loaded into the output register,
// so the block takes no new request until then; a result may wait in the output register.
// Reset (synchronous, active low) marks every block free and every directory slot empty;
// the directory memory itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module contiguous_extent_allocator #(
    parameter int DISK_BLOCKS = cea_pkg::DISK_BLOCKS_DEF,
    parameter int DIR_SLOTS   = cea_pkg::DIR_SLOTS_DEF,
    parameter int NAME_CHARS  = cea_pkg::NAME_CHARS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_action,
    input  wire logic [cea_pkg::HEAD_W-1:0]    i_name_head,
    input  wire logic [cea_pkg::TAIL_W-1:0]    i_name_tail,
    input  wire logic [cea_pkg::START_W-1:0]   i_start_block,
    input  wire logic [cea_pkg::COUNT_W-1:0]   i_block_count,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [cea_pkg::STATUS_W-1:0]       o_status,
    output logic [cea_pkg::SLOT_W-1:0]         o_slot,
    output logic [cea_pkg::MAP_W-1:0]          o_free_map
);

    localparam int           AW     = $clog2(DIR_SLOTS);
    localparam logic [AW:0]  SlotsN = (AW+1)'(DIR_SLOTS);
    localparam logic [AW-1:0] Last  = AW'(DIR_SLOTS - 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CREATE = 4'b0010,
        S_SEARCH = 4'b0100,
        S_PUSH   = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    logic [cea_pkg::NAME_W-1:0]      r_name;
    logic [cea_pkg::START_W-1:0]     r_start;
    logic [cea_pkg::COUNT_W-1:0]     r_count;
    logic [DIR_SLOTS-1:0]            r_live, n_live;
    logic [AW:0]                     r_rd_idx, n_rd_idx;
    logic                            r_chk_vld, n_chk_vld;
    logic [AW-1:0]                   r_chk_idx, n_chk_idx;
    cea_pkg::t_status                r_status, n_status;
    logic [AW-1:0]                   r_slot_idx, n_slot_idx;
    logic                            r_out_vld;
    logic [cea_pkg::STATUS_W-1:0]    r_out_status;
    logic [cea_pkg::SLOT_W-1:0]      r_out_slot;
    logic [cea_pkg::MAP_W-1:0]       r_out_map;

    logic                            w_accept;
    logic                            w_load;
    logic                            w_have_free;
    logic [AW-1:0]                   w_free_idx;
    logic                            w_match;
    logic                            w_wr_en;
    logic                            w_rd_en;
    cea_pkg::t_entry                 w_wr_data;
    cea_pkg::t_entry                 w_rd_data;
    cea_pkg::t_map_ctl               w_map_ctl;
    logic                            w_fits;
    logic [DISK_BLOCKS-1:0]          w_free_bits;
    logic [cea_pkg::MAP_W-1:0]       w_map32;
    logic [cea_pkg::SLOT_W-1:0]      w_slot4;

    cea_dir_ram #(
        .DIR_SLOTS (DIR_SLOTS),
        .AW        (AW)
    ) u_dir (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_free_idx),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_idx[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    cea_free_map #(
        .DISK_BLOCKS (DISK_BLOCKS)
    ) u_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_map_ctl),
        .o_fits      (w_fits),
        .o_free_bits (w_free_bits)
    );

    generate
        if (DISK_BLOCKS >= cea_pkg::MAP_W) begin : g_map_cut
            assign w_map32 = w_free_bits[cea_pkg::MAP_W-1:0];
        end else begin : g_map_ext
            assign w_map32 = {{(cea_pkg::MAP_W - DISK_BLOCKS){1'b0}}, w_free_bits};
        end
        if (AW >= cea_pkg::SLOT_W) begin : g_slot_cut
            assign w_slot4 = r_slot_idx[cea_pkg::SLOT_W-1:0];
        end else begin : g_slot_ext
            assign w_slot4 = {{(cea_pkg::SLOT_W - AW){1'b0}}, r_slot_idx};
        end
    endgenerate

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_load     = (r_state == S_PUSH) && (!r_out_vld || !i_out_stall);
    assign w_wr_data  = '{name: r_name, start: r_start, length: r_count};
    assign w_match    = r_chk_vld && r_live[r_chk_idx] && (w_rd_data.name == r_name);

    always_comb begin
        w_have_free = 1'b0;
        w_free_idx  = '0;
        for (int s = DIR_SLOTS - 1; s >= 0; s--) begin
            if (!r_live[s]) begin
                w_have_free = 1'b1;
                w_free_idx  = AW'(s);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_live     = r_live;
        n_rd_idx   = r_rd_idx;
        n_chk_vld  = 1'b0;
        n_chk_idx  = r_chk_idx;
        n_status   = r_status;
        n_slot_idx = r_slot_idx;
        w_wr_en    = 1'b0;
        w_rd_en    = 1'b0;
        w_map_ctl  = '{set_used: 1'b0, set_free: 1'b0, start: r_start, count: r_count};
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state  = i_action ? S_SEARCH : S_CREATE;
                    n_rd_idx = '0;
                end
            end
            S_CREATE: begin
                n_state    = S_PUSH;
                n_slot_idx = '0;
                if (!w_fits) begin
                    n_status = cea_pkg::ST_NOSPACE;
                end else if (!w_have_free) begin
                    n_status = cea_pkg::ST_DIRFULL;
                end else begin
                    n_status           = cea_pkg::ST_STORED;
                    n_slot_idx         = w_free_idx;
                    n_live[w_free_idx] = 1'b1;
                    w_wr_en            = 1'b1;
                    w_map_ctl.set_used = 1'b1;
                end
            end
            S_SEARCH: begin
                w_rd_en   = (r_rd_idx < SlotsN);
                n_chk_vld = w_rd_en;
                n_chk_idx = r_rd_idx[AW-1:0];
                n_rd_idx  = w_rd_en ? r_rd_idx + 1'b1 : r_rd_idx;
                w_map_ctl.start = w_rd_data.start;
                w_map_ctl.count = w_rd_data.length;
                if (w_match) begin
                    n_state            = S_PUSH;
                    n_status           = cea_pkg::ST_DELETED;
                    n_slot_idx         = r_chk_idx;
                    n_live[r_chk_idx]  = 1'b0;
                    w_map_ctl.set_free = 1'b1;
                    n_chk_vld          = 1'b0;
                end else if (r_chk_vld && (r_chk_idx == Last)) begin
                    n_state    = S_PUSH;
                    n_status   = cea_pkg::ST_NOTFOUND;
                    n_slot_idx = '0;
                    n_chk_vld  = 1'b0;
                end
            end
            S_PUSH: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_live    <= '0;
            r_rd_idx  <= '0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_live    <= n_live;
            r_rd_idx  <= n_rd_idx;
            r_chk_vld <= n_chk_vld;
            r_out_vld <= w_load || (r_out_vld && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx  <= n_chk_idx;
        r_status   <= n_status;
        r_slot_idx <= n_slot_idx;
        if (w_accept) begin
            r_name  <= cea_pkg::norm_name(i_name_head, i_name_tail, NAME_CHARS);
            r_start <= i_start_block;
            r_count <= i_block_count;
        end
        if (w_load) begin
            r_out_status <= r_status;
            r_out_slot   <= w_slot4;
            r_out_map    <= w_map32;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_status    = r_out_status;
    assign o_slot      = r_out_slot;
    assign o_free_map  = r_out_map;

    a_live_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_PUSH) |=> $stable(r_live))
        else $error("Slot occupancy changed outside create or search.");

    a_map_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_PUSH) |=> $stable(w_free_bits))
        else $error("Free map changed outside create or search.");

    a_store_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CREATE && w_fits && w_have_free) |=> r_live[$past(w_free_idx)])
        else $error("Stored extent did not occupy its slot.");

    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_rd_idx <= SlotsN))
        else $error("Directory search ran past the last slot.");

    a_push_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_out_vld && r_state == S_IDLE))
        else $error("Result load did not complete the transaction.");

endmodule

`default_nettype wire

### rtl/cea_dir_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module cea_dir_ram #(
    parameter int DIR_SLOTS = cea_pkg::DIR_SLOTS_DEF,
    parameter int AW        = $clog2(DIR_SLOTS)
) (
    input  wire logic            i_clk,
    input  wire logic            i_wr_en,
    input  wire logic [AW-1:0]   i_wr_addr,
    input  wire cea_pkg::t_entry i_wr_data,
    input  wire logic            i_rd_en,
    input  wire logic [AW-1:0]   i_rd_addr,
    output cea_pkg::t_entry      o_rd_data
);

    cea_pkg::t_entry r_mem [DIR_SLOTS];
    cea_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### rtl/cea_free_map.sv
`timescale 1ns / 1ps
`default_nettype none

module cea_free_map #(
    parameter int DISK_BLOCKS = cea_pkg::DISK_BLOCKS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire cea_pkg::t_map_ctl      i_ctl,
    output logic                        o_fits,
    output logic [DISK_BLOCKS-1:0]      o_free_bits
);

    localparam logic [6:0] DiskLim = 7'(DISK_BLOCKS);

    logic [6:0]             w_end;
    logic                   w_inside;
    logic [DISK_BLOCKS-1:0] w_mask;
    logic [DISK_BLOCKS-1:0] r_free;
    logic [DISK_BLOCKS-1:0] n_free;

    always_comb begin
        w_end    = 7'(i_ctl.start) + 7'(i_ctl.count);
        w_inside = (w_end <= DiskLim);
        for (int b = 0; b < DISK_BLOCKS; b++) begin
            w_mask[b] = (7'(b) >= 7'(i_ctl.start)) && (7'(b) < w_end);
        end
        o_fits = w_inside && ((r_free & w_mask) == w_mask);
        n_free = r_free;
        if (i_ctl.set_used) begin
            n_free = r_free & ~w_mask;
        end else if (i_ctl.set_free) begin
            n_free = r_free | w_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '1;
        end else begin
            r_free <= n_free;
        end
    end

    assign o_free_bits = r_free;

endmodule

`default_nettype wire
